/* hw/rtl/ssnf_pkg.sv */
// shared types, command codes and segment table for the seven-segment number framer
package ssnf_pkg;

  typedef logic [7:0] byte_t;
  typedef logic [3:0] bcd_t;
  typedef logic [2:0] bright_t;

  localparam int unsigned PADDR_W       = 3;
  localparam bright_t     BRIGHT_RESET  = 3'd7;

  localparam byte_t CMD_DATA       = 8'h40;
  localparam byte_t CMD_ADDR       = 8'hC0;
  localparam byte_t CMD_DISPLAY_ON = 8'h88;
  localparam byte_t SEG_BLANK      = 8'h00;

  // control between converter and byte sequencer
  typedef struct packed {
    logic done;
    logic clear;
  } conv_stat_t;

  function automatic int unsigned pow10(input int unsigned n);
    int unsigned r;
    r = 1;
    for (int unsigned k = 0; k < n; k++) begin
      r = r * 10;
    end
    return r;
  endfunction

  function automatic byte_t seg_of(input bcd_t d);
    byte_t s;
    case (d)
      4'd0: s = 8'h3f;
      4'd1: s = 8'h06;
      4'd2: s = 8'h5b;
      4'd3: s = 8'h4f;
      4'd4: s = 8'h66;
      4'd5: s = 8'h6d;
      4'd6: s = 8'h7d;
      4'd7: s = 8'h07;
      4'd8: s = 8'h7f;
      4'd9: s = 8'h6f;
      default: s = SEG_BLANK;
    endcase
    return s;
  endfunction

  function automatic bcd_t bcd_adj(input bcd_t d);
    return (d >= 4'd5) ? bcd_t'(d + 4'd3) : d;
  endfunction

endpackage

/* hw/rtl/seven_segment_number_framer.sv */
// top level of the seven-segment number framer: register port, clamp and datapath
//
// Input channel (in_valid_i / in_ready_o) takes one request word: action_i = 0
// shows value_i clamped to 0..10^DIGIT_COUNT-1, action_i = 1 blanks all digits.
// Output channel (out_valid_o / out_ready_i) gives one display byte per word
// with frame_start_o, frame_end_o and last_o on the final byte of a request.
// A show request gives 2*DIGIT_COUNT+2 words (10 at four digits), a clear
// request 2*DIGIT_COUNT words.
// The value is converted in a row of decimal digit cells, two bits per cycle;
// the first byte of a request is valid once the converter has flagged it done
// and the byte sequencer has taken its digits.
// Conversion of the next request overlaps the byte output of the current one.
// When the receiver stalls, the current byte holds and at most one converted
// request waits behind it; in_ready_o drops until that one moves on.
// Reset empties both stages and sets brightness to 7. The APB register at
// byte address 0 holds brightness in bits 2:0; pready is always high.
module seven_segment_number_framer #(
  parameter int unsigned DIGIT_COUNT = 4
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [ssnf_pkg::PADDR_W-1:0]   paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           action_i,
  input  logic signed [31:0]             value_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output ssnf_pkg::byte_t                out_byte_o,
  output logic                           frame_start_o,
  output logic                           frame_end_o,
  output logic                           last_o
);
  import ssnf_pkg::*;

  localparam logic [31:0] LIMIT = 32'(pow10(DIGIT_COUNT) - 1);
  localparam int unsigned NBITS = $clog2(pow10(DIGIT_COUNT));
  localparam int unsigned VW    = NBITS + (NBITS % 2);

  bright_t       bright_q;
  logic          start;
  logic          chain_ready;
  logic          take;
  logic [31:0]   clamped;
  conv_stat_t    stat;
  bcd_t          digits [DIGIT_COUNT];

  // register port
  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'd0 : {29'd0, bright_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bright_q <= BRIGHT_RESET;
    end else if (psel && penable && pwrite && !paddr[2]) begin
      bright_q <= pwdata[2:0];
    end
  end

  // clamp to the displayable range; clear requests pass zero
  always_comb begin
    if (value_i[31] || action_i) begin
      clamped = '0;
    end else if (32'(value_i) > LIMIT) begin
      clamped = LIMIT;
    end else begin
      clamped = 32'(value_i);
    end
  end

  assign in_ready_o = chain_ready;
  assign start      = in_valid_i && chain_ready;

  ssnf_bcd_chain #(
    .DIGIT_COUNT (DIGIT_COUNT),
    .VW          (VW)
  ) u_chain (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .clear_i  (action_i),
    .value_i  (clamped[VW-1:0]),
    .take_i   (take),
    .ready_o  (chain_ready),
    .stat_o   (stat),
    .digits_o (digits)
  );

  ssnf_emitter #(
    .DIGIT_COUNT (DIGIT_COUNT)
  ) u_emitter (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .stat_i        (stat),
    .digits_i      (digits),
    .bright_i      (bright_q),
    .take_o        (take),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_byte_o    (out_byte_o),
    .frame_start_o (frame_start_o),
    .frame_end_o   (frame_end_o),
    .last_o        (last_o)
  );

endmodule

/* hw/rtl/ssnf_bcd_cell.sv */
// one decimal digit cell of the shift-and-add-3 chain, two bits per cycle while enabled
module ssnf_bcd_cell (
  input  logic              clk_i,
  input  logic              clr_i,
  input  logic              en_i,
  input  logic [1:0]        cin_i,
  output logic [1:0]        cout_o,
  output ssnf_pkg::bcd_t    digit_o
);
  import ssnf_pkg::*;

  bcd_t digit_q, digit_d;
  bcd_t a1, mid, a2;

  always_comb begin
    a1      = bcd_adj(digit_q);
    mid     = {a1[2:0], cin_i[1]};
    a2      = bcd_adj(mid);
    cout_o  = {a1[3], a2[3]};
    digit_d = {a2[2:0], cin_i[0]};
  end

  always_ff @(posedge clk_i) begin
    if (clr_i) begin
      digit_q <= '0;
    end else if (en_i) begin
      digit_q <= digit_d;
    end
  end

  assign digit_o = digit_q;

endmodule

/* hw/rtl/ssnf_bcd_chain.sv */
// binary to decimal converter: shift register feeding a row of digit cells
module ssnf_bcd_chain #(
  parameter int unsigned DIGIT_COUNT = 4,
  parameter int unsigned VW          = 14
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic                   clear_i,
  input  logic [VW-1:0]          value_i,
  input  logic                   take_i,
  output logic                   ready_o,
  output ssnf_pkg::conv_stat_t   stat_o,
  output ssnf_pkg::bcd_t         digits_o [DIGIT_COUNT]
);
  import ssnf_pkg::*;

  localparam int unsigned STEPS = VW / 2;
  localparam int unsigned CW    = $clog2(STEPS + 1);

  logic [VW-1:0] bin_q, bin_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic          clear_q;
  logic [1:0]    carry [DIGIT_COUNT];

  assign ready_o = !busy_q && (!done_q || take_i);
  assign carry[0] = bin_q[VW-1 -: 2];

  for (genvar i = 0; i < DIGIT_COUNT; i++) begin : g_cell
    if (i < DIGIT_COUNT - 1) begin : g_mid
      ssnf_bcd_cell u_cell (
        .clk_i   (clk_i),
        .clr_i   (start_i),
        .en_i    (busy_q),
        .cin_i   (carry[i]),
        .cout_o  (carry[i+1]),
        .digit_o (digits_o[i])
      );
    end else begin : g_top
      ssnf_bcd_cell u_cell (
        .clk_i   (clk_i),
        .clr_i   (start_i),
        .en_i    (busy_q),
        .cin_i   (carry[i]),
        .cout_o  (),
        .digit_o (digits_o[i])
      );
    end
  end

  always_comb begin
    bin_d  = bin_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = done_q;
    if (take_i) begin
      done_d = 1'b0;
    end
    if (start_i) begin
      bin_d  = value_i;
      cnt_d  = CW'(STEPS);
      busy_d = 1'b1;
    end else if (busy_q) begin
      bin_d = {bin_q[VW-3:0], 2'b00};
      cnt_d = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q <= bin_d;
    if (start_i) begin
      clear_q <= clear_i;
    end
  end

  assign stat_o.done  = done_q;
  assign stat_o.clear = clear_q;

endmodule

/* hw/rtl/ssnf_emitter.sv */
// byte sequencer: walks the frame of one request and drives the output channel
module ssnf_emitter #(
  parameter int unsigned DIGIT_COUNT = 4
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  ssnf_pkg::conv_stat_t   stat_i,
  input  ssnf_pkg::bcd_t         digits_i [DIGIT_COUNT],
  input  ssnf_pkg::bright_t      bright_i,
  output logic                   take_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output ssnf_pkg::byte_t        out_byte_o,
  output logic                   frame_start_o,
  output logic                   frame_end_o,
  output logic                   last_o
);
  import ssnf_pkg::*;

  localparam int unsigned PW = $clog2(2 * DIGIT_COUNT + 2);
  localparam int unsigned IW = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;

  logic [PW-1:0] pos_q, pos_d;
  logic          busy_q, busy_d;
  logic          clear_q;
  byte_t         segs_q [DIGIT_COUNT];
  logic [PW-1:0] end_pos;
  logic [PW-1:0] sidx;
  logic          fire;

  assign end_pos     = clear_q ? PW'(2 * DIGIT_COUNT) : PW'(2 * DIGIT_COUNT + 1);
  assign last_o      = (pos_q == end_pos);
  assign out_valid_o = busy_q;
  assign fire        = busy_q && out_ready_i;
  assign take_o      = stat_i.done && (!busy_q || (fire && last_o));
  assign sidx        = PW'((pos_q >> 1) - PW'(1));

  always_comb begin
    if (pos_q == '0) begin
      out_byte_o    = CMD_DATA;
      frame_start_o = 1'b1;
      frame_end_o   = 1'b1;
    end else if (last_o && !clear_q) begin
      out_byte_o    = CMD_DISPLAY_ON | {5'b0, bright_i};
      frame_start_o = 1'b1;
      frame_end_o   = 1'b1;
    end else if (pos_q[0]) begin
      out_byte_o    = CMD_ADDR | byte_t'(pos_q >> 1);
      frame_start_o = 1'b1;
      frame_end_o   = 1'b0;
    end else begin
      out_byte_o    = segs_q[sidx[IW-1:0]];
      frame_start_o = 1'b0;
      frame_end_o   = 1'b1;
    end
  end

  always_comb begin
    pos_d  = pos_q;
    busy_d = busy_q;
    if (fire) begin
      if (last_o) begin
        busy_d = 1'b0;
      end else begin
        pos_d = pos_q + PW'(1);
      end
    end
    if (take_o) begin
      busy_d = 1'b1;
      pos_d  = stat_i.clear ? PW'(1) : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      pos_q  <= '0;
    end else begin
      busy_q <= busy_d;
      pos_q  <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o) begin
      clear_q <= stat_i.clear;
      for (int j = 0; j < DIGIT_COUNT; j++) begin
        segs_q[j] <= stat_i.clear ? SEG_BLANK : seg_of(digits_i[DIGIT_COUNT-1-j]);
      end
    end
  end

endmodule

/* dv/tb_seven_segment_number_framer.sv */
// testbench for the seven-segment number framer: byte frames checked against a local predictor
`timescale 1ns / 100ps

module tb_seven_segment_number_framer;
  import ssnf_pkg::*;

  localparam int unsigned DIGITS      = 4;
  localparam int unsigned PHASES      = 6;
  localparam int unsigned PHASE_ITEMS = 78;
  localparam int unsigned SETTLE      = 16;
  localparam int unsigned LIMIT       = 300000;
  localparam int unsigned HOLD_CYCLES = 400;

  localparam byte_t SEG_MAP [10] = '{8'h3f, 8'h06, 8'h5b, 8'h4f, 8'h66,
                                     8'h7d - 8'h10, 8'h7d, 8'h07, 8'h7f, 8'h6f};

  typedef struct packed {
    byte_t data;
    logic  opens;
    logic  closes;
    logic  last;
  } display_byte_t;

  typedef struct packed {
    logic        act;
    logic [31:0] val;
    logic        typed;
    logic [31:0] segs;
  } dir_row_t;

  // typed segment bytes, most significant digit in the top byte
  localparam dir_row_t DIR_TAB [17] = '{
    '{1'b0, 32'd0,         1'b1, 32'h3f3f3f3f},
    '{1'b0, 32'd9999,      1'b1, 32'h6f6f6f6f},
    '{1'b0, 32'hffffffff,  1'b1, 32'h3f3f3f3f},
    '{1'b0, 32'h80000000,  1'b1, 32'h3f3f3f3f},
    '{1'b0, 32'h7fffffff,  1'b1, 32'h6f6f6f6f},
    '{1'b0, 32'd10000,     1'b1, 32'h6f6f6f6f},
    '{1'b1, 32'd0,         1'b0, 32'h0},
    '{1'b1, 32'hffffffff,  1'b0, 32'h0},
    '{1'b0, 32'd1234,      1'b1, 32'h065b4f66},
    '{1'b0, 32'd5678,      1'b1, 32'h6d7d077f},
    '{1'b0, 32'd9998,      1'b0, 32'h0},
    '{1'b0, 32'd1,         1'b0, 32'h0},
    '{1'b0, 32'd1000,      1'b0, 32'h0},
    '{1'b0, 32'd90,        1'b0, 32'h0},
    '{1'b0, 32'd4040,      1'b0, 32'h0},
    '{1'b1, 32'd9999,      1'b0, 32'h0},
    '{1'b0, 32'h0000ffff,  1'b1, 32'h6f6f6f6f}
  };

  logic                 clk_i;
  logic                 rst_ni;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [PADDR_W-1:0]   paddr;
  logic [31:0]          pwdata;
  logic [31:0]          prdata;
  logic                 pready;
  logic                 in_valid_i;
  logic                 in_ready_o;
  logic                 action_i;
  logic signed [31:0]   value_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  byte_t                out_byte_o;
  logic                 frame_start_o;
  logic                 frame_end_o;
  logic                 last_o;

  display_byte_t pending_bytes [$];
  bright_t       bright;
  int unsigned   err_cnt = 0;
  int unsigned   cycle_cnt = 0;
  bit            long_hold_pending = 1'b0;

  seven_segment_number_framer #(
    .DIGIT_COUNT(DIGITS)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .action_i     (action_i),
    .value_i      (value_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_byte_o   (out_byte_o),
    .frame_start_o(frame_start_o),
    .frame_end_o  (frame_end_o),
    .last_o       (last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
    err_cnt++;
  endtask

  // clamp, split into decimal digits and map to segments, first digit in the top byte
  function automatic logic [DIGITS*8-1:0] digit_segments(input logic [31:0] raw);
    longint unsigned top;
    longint unsigned v;
    logic [DIGITS*8-1:0] r;
    top = 1;
    for (int k = 0; k < DIGITS; k++) top = top * 10;
    top = top - 1;
    v = raw[31] ? 64'd0 : {32'd0, raw};
    if (v > top) v = top;
    for (int k = DIGITS - 1; k >= 0; k--) begin
      r[(DIGITS-1-k)*8 +: 8] = SEG_MAP[v % 10];
      v = v / 10;
    end
    return r;
  endfunction

  task automatic queue_frames(input logic act, input logic [DIGITS*8-1:0] segs);
    byte_t seg;
    if (!act) pending_bytes.push_back(display_byte_t'{CMD_DATA, 1'b1, 1'b1, 1'b0});
    for (int i = 0; i < DIGITS; i++) begin
      seg = act ? SEG_BLANK : segs[(DIGITS-1-i)*8 +: 8];
      pending_bytes.push_back(display_byte_t'{CMD_ADDR | byte_t'(i), 1'b1, 1'b0, 1'b0});
      pending_bytes.push_back(display_byte_t'{seg, 1'b0, 1'b1, act && (i == DIGITS - 1)});
    end
    if (!act) begin
      pending_bytes.push_back(display_byte_t'{CMD_DISPLAY_ON | {5'd0, bright}, 1'b1, 1'b1,
                                              1'b1});
    end
  endtask

  task automatic send_word(input logic act, input logic [31:0] val,
                           input logic [DIGITS*8-1:0] segs);
    in_valid_i <= 1'b1;
    action_i   <= act;
    value_i    <= val;
    do @(posedge clk_i); while (!in_ready_o);
    queue_frames(act, segs);
  endtask

  // write a register, then read back the brightness register at address 0
  task automatic cfg_write(input logic [PADDR_W-1:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (addr == '0) bright = data[2:0];
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata[2:0] !== bright) begin
      report("brightness readback", 32'(prdata[2:0]), 32'(bright));
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic settle();
    while (pending_bytes.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_value();
    logic [31:0] r;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: r = $urandom_range(0, 9999);
      4: r = $urandom_range(9990, 10010);
      5: r = $urandom_range(0, 20);
      6: r = 32'd0 - $urandom_range(1, 50);
      7: r = {1'b1, 31'($urandom)};
      default: r = $urandom;
    endcase
    return r;
  endfunction

  initial begin : rx_proc
    int unsigned mode;
    int unsigned left;
    int unsigned hold;
    bit          hold_taken;
    out_ready_i <= 1'b0;
    mode = 0;
    left = 0;
    hold = 0;
    hold_taken = 1'b0;
    forever begin
      @(posedge clk_i);
      if (long_hold_pending && !hold_taken) begin
        hold_taken = 1'b1;
        hold = HOLD_CYCLES;
      end
      if (left == 0) begin
        mode = $urandom_range(0, 3);
        left = $urandom_range(20, 200);
      end
      left--;
      if (hold != 0) begin
        hold--;
        out_ready_i <= 1'b0;
      end else begin
        case (mode)
          0: out_ready_i <= 1'b1;
          1: out_ready_i <= 1'($urandom_range(0, 1));
          2: out_ready_i <= ($urandom_range(0, 3) == 0);
          default: out_ready_i <= ((left % 5) != 0);
        endcase
      end
    end
  end

  always @(posedge clk_i) begin : mon
    display_byte_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_bytes.size() == 0) begin
        report("unexpected word", 32'(out_byte_o), 32'd0);
      end else begin
        e = pending_bytes.pop_front();
        if (out_byte_o !== e.data) report("out_byte", 32'(out_byte_o), 32'(e.data));
        if (frame_start_o !== e.opens) begin
          report("frame_start", 32'(frame_start_o), 32'(e.opens));
        end
        if (frame_end_o !== e.closes) begin
          report("frame_end", 32'(frame_end_o), 32'(e.closes));
        end
        if (last_o !== e.last) report("last", 32'(last_o), 32'(e.last));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt == LIMIT) begin
      $display("tb_seven_segment_number_framer: errors");
      $finish;
    end
  end

  initial begin : main_proc
    int unsigned n_items;
    int unsigned burst;
    int unsigned gap;
    logic        act;
    logic [31:0] val;
    rst_ni     <= 1'b0;
    psel       <= 1'b0;
    penable    <= 1'b0;
    pwrite     <= 1'b0;
    paddr      <= '0;
    pwdata     <= '0;
    in_valid_i <= 1'b0;
    action_i   <= 1'b0;
    value_i    <= '0;
    bright = BRIGHT_RESET;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (3) @(posedge clk_i);

    foreach (DIR_TAB[r]) begin
      send_word(DIR_TAB[r].act, DIR_TAB[r].val,
                DIR_TAB[r].typed ? DIR_TAB[r].segs : digit_segments(DIR_TAB[r].val));
    end
    in_valid_i <= 1'b0;

    for (int p = 0; p < PHASES; p++) begin
      settle();
      // address past the last register, must not change brightness
      if (p == 2) cfg_write(PADDR_W'(4), $urandom);
      val = $urandom;
      val[2:0] = (p == 0) ? 3'd0 : (p == 1) ? 3'd7 : 3'($urandom_range(0, 7));
      cfg_write('0, val);
      if (p == 3) long_hold_pending = 1'b1;
      n_items = 0;
      while (n_items < PHASE_ITEMS) begin
        burst = $urandom_range(1, 16);
        for (int b = 0; b < burst && n_items < PHASE_ITEMS; b++) begin
          act = ($urandom_range(0, 6) == 0);
          val = rand_value();
          send_word(act, val, digit_segments(val));
          n_items++;
        end
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        if ($urandom_range(0, 15) == 0) gap = $urandom_range(10, 25);
        if (gap == 0 && n_items >= PHASE_ITEMS) gap = 1;
        if (gap > 0) begin
          in_valid_i <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
    end

    settle();
    if (err_cnt == 0) begin
      $display("tb_seven_segment_number_framer: clean");
    end else begin
      $display("tb_seven_segment_number_framer: errors");
    end
    $finish;
  end

endmodule
